// ===== sv/usc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// usc_pkg
// Shared types, constants and tables for the seconds-to-calendar converter.
// ----------------------------------------------------------------------------
package usc_pkg;

    // Field widths
    localparam int TS_W    = 32;
    localparam int DAYS_W  = 16;   // whole days since the epoch, below 49711
    localparam int SOD_W   = 17;   // second of day, below 86400
    localparam int MOD_W   = 11;   // minute of day, below 1440
    localparam int WQ_W    = 14;   // whole weeks in the shifted day count
    localparam int YLEN_W  = 9;    // year length in days
    localparam int MLEN_W  = 5;    // month length in days

    // Divisors and offsets
    localparam logic [TS_W-1:0]   SEC_PER_DAY    = 32'd86400;
    localparam logic [SOD_W-1:0]  SEC_PER_MIN    = 17'd60;
    localparam logic [MOD_W-1:0]  MIN_PER_HOUR   = 11'd60;
    localparam logic [DAYS_W-1:0] DAYS_PER_WEEK  = 16'd7;
    localparam logic [DAYS_W-1:0] EPOCH_WEEK_ADJ = 16'd3;

    // Reciprocals for division by constants, each exact over its dividend range
    localparam logic [25:0] DAY_RECIP  = 26'd50903317;  // 2^35 / 675, rounded up
    localparam logic [16:0] WEEK_RECIP = 17'd74899;     // 2^19 / 7, rounded up
    localparam logic [15:0] MIN_RECIP  = 16'd34953;     // 2^19 / 15, rounded up

    // Year walk start: 1970 and its residues
    localparam logic [7:0] YEAR_OFS_EPOCH = 8'd226;  // (1970 - 2000) mod 256
    localparam logic [1:0] EPOCH_MOD4     = 2'd2;
    localparam logic [6:0] EPOCH_MOD100   = 7'd70;
    localparam logic [8:0] EPOCH_MOD400   = 9'd370;
    localparam logic [6:0] LAST_MOD100    = 7'd99;
    localparam logic [8:0] LAST_MOD400    = 9'd399;

    localparam logic [YLEN_W-1:0] DAYS_LEAP   = 9'd366;
    localparam logic [YLEN_W-1:0] DAYS_COMMON = 9'd365;

    localparam logic [3:0] LAST_MONTH = 4'd11;  // December, zero based

    // Queue between front and back
    localparam int QDEPTH = 2;
    localparam int QPTR_W = 1;
    localparam int QCNT_W = 2;

    // One word handed from front to back
    typedef struct packed {
        logic [TS_W-1:0]   ts;
        logic [5:0]        sec;
        logic [5:0]        min;
        logic [4:0]        hour;
        logic [2:0]        wday;
        logic [DAYS_W-1:0] days;
    } usc_item_t;

    // Month length table, month is zero based
    function automatic logic [MLEN_W-1:0] month_len(input logic leap, input logic [3:0] month);
        logic [MLEN_W-1:0] len;
        case (month)
            4'd1:                       len = leap ? 5'd29 : 5'd28;
            4'd3, 4'd5, 4'd8, 4'd10:    len = 5'd30;
            default:                    len = 5'd31;
        endcase
        return len;
    endfunction

endpackage

// ===== sv/usc_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// usc_front
// Accepts a timestamp and splits it into time of day, day count and weekday
// with reciprocal multiplications by constants, one product a cycle.
// ----------------------------------------------------------------------------
module usc_front
    import usc_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [TS_W-1:0]   timestamp,
    output logic              push_valid,
    input  logic              push_ready,
    output usc_item_t         push_item
);

    localparam logic [2:0] F_IDLE  = 3'd0;
    localparam logic [2:0] F_DAY   = 3'd1;
    localparam logic [2:0] F_SOD   = 3'd2;
    localparam logic [2:0] F_MOD   = 3'd3;
    localparam logic [2:0] F_SPLIT = 3'd4;
    localparam logic [2:0] F_MIN   = 3'd5;
    localparam logic [2:0] F_PUSH  = 3'd6;

    logic [2:0]        state_reg, state_next;
    logic [TS_W-1:0]   ts_reg;
    logic [DAYS_W-1:0] days_reg;
    logic [SOD_W-1:0]  sod_reg;
    logic [WQ_W-1:0]   wq_reg;
    logic [MOD_W-1:0]  mod_reg;
    logic [5:0]        sec_reg;
    logic [5:0]        min_reg;
    logic [4:0]        hour_reg;
    logic [2:0]        wday_reg;

    logic [50:0]       day_prod;
    logic [TS_W-1:0]   day_base;
    logic [TS_W-1:0]   sod_full;
    logic [DAYS_W-1:0] week_n;
    logic [32:0]       week_prod;
    logic [DAYS_W-1:0] week_base;
    logic [DAYS_W-1:0] week_rem;
    logic [30:0]       min_prod;
    logic [SOD_W-1:0]  min_base;
    logic [SOD_W-1:0]  sec_full;
    logic [24:0]       hour_prod;
    logic [MOD_W-1:0]  hour_base;
    logic [MOD_W-1:0]  min_full;
    logic              accept;

    assign accept = in_valid && in_ready;

    // Days: drop the factor of 128, then divide by 675 by reciprocal
    assign day_prod = {26'd0, ts_reg[TS_W-1:7]} * {25'd0, DAY_RECIP};

    // Second of day from the day count
    assign day_base = {16'd0, days_reg} * SEC_PER_DAY;
    assign sod_full = ts_reg - day_base;

    // Weekday: shift so the epoch lands on Thursday, then take it modulo 7
    assign week_n    = days_reg + EPOCH_WEEK_ADJ;
    assign week_prod = {17'd0, week_n} * {16'd0, WEEK_RECIP};
    assign week_base = {2'd0, wq_reg} * DAYS_PER_WEEK;
    assign week_rem  = week_n - week_base;

    // Minute of day: drop the factor of 4, then divide by 15 by reciprocal
    assign min_prod = {16'd0, sod_reg[SOD_W-1:2]} * {15'd0, MIN_RECIP};
    assign min_base = {6'd0, mod_reg} * SEC_PER_MIN;
    assign sec_full = sod_reg - min_base;

    // Hour of day from the minute of day, same reciprocal
    assign hour_prod = {16'd0, mod_reg[MOD_W-1:2]} * {9'd0, MIN_RECIP};
    assign hour_base = {6'd0, hour_reg} * MIN_PER_HOUR;
    assign min_full  = mod_reg - hour_base;

    // Sequence the steps
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            F_IDLE:
            begin
                if (accept)
                begin
                    state_next = F_DAY;
                end
            end
            F_DAY:   state_next = F_SOD;
            F_SOD:   state_next = F_MOD;
            F_MOD:   state_next = F_SPLIT;
            F_SPLIT: state_next = F_MIN;
            F_MIN:   state_next = F_PUSH;
            F_PUSH:
            begin
                if (push_ready)
                begin
                    state_next = F_IDLE;
                end
            end
            default:
            begin
                state_next = F_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= F_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Datapath registers, capture each field as its step ends
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            ts_reg <= timestamp;
        end
        if (state_reg == F_DAY)
        begin
            days_reg <= day_prod[50:35];
        end
        if (state_reg == F_SOD)
        begin
            sod_reg <= sod_full[SOD_W-1:0];
            wq_reg  <= week_prod[32:19];
        end
        if (state_reg == F_MOD)
        begin
            mod_reg  <= min_prod[29:19];
            wday_reg <= week_rem[2:0] + 3'd1;
        end
        if (state_reg == F_SPLIT)
        begin
            sec_reg  <= sec_full[5:0];
            hour_reg <= hour_prod[23:19];
        end
        if (state_reg == F_MIN)
        begin
            min_reg <= min_full[5:0];
        end
    end

    assign in_ready   = (state_reg == F_IDLE);
    assign push_valid = (state_reg == F_PUSH);

    assign push_item.ts   = ts_reg;
    assign push_item.sec  = sec_reg;
    assign push_item.min  = min_reg;
    assign push_item.hour = hour_reg;
    assign push_item.wday = wday_reg;
    assign push_item.days = days_reg;

endmodule

// ===== sv/usc_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// usc_queue
// Short first-in first-out queue that decouples the front from the back.
// ----------------------------------------------------------------------------
module usc_queue
    import usc_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push_valid,
    output logic       push_ready,
    input  usc_item_t  push_item,
    output logic       pop_valid,
    input  logic       pop_ready,
    output usc_item_t  pop_item
);

    usc_item_t         slot_reg [QDEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QCNT_W-1:0] count_reg;
    logic              do_push;
    logic              do_pop;

    assign push_ready = (count_reg != QCNT_W'(QDEPTH));
    assign pop_valid  = (count_reg != '0);
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;
    assign pop_item   = slot_reg[rd_ptr_reg];

    // Advance pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    // Store the pushed word
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

// ===== sv/usc_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// usc_back
// Walks whole years from 1970, then the months of the year found, one year
// or one month a cycle, and holds the finished date for the output.
// ----------------------------------------------------------------------------
module usc_back
    import usc_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              pop_valid,
    output logic              pop_ready,
    input  usc_item_t         pop_item,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [TS_W-1:0]   echo_seconds,
    output logic [5:0]        second_of_minute,
    output logic [5:0]        minute_of_hour,
    output logic [4:0]        hour_of_day,
    output logic [2:0]        day_of_week,
    output logic [7:0]        year_offset,
    output logic [3:0]        month_number,
    output logic [4:0]        day_of_month
);

    localparam logic [1:0] B_IDLE  = 2'd0;
    localparam logic [1:0] B_YEAR  = 2'd1;
    localparam logic [1:0] B_MONTH = 2'd2;
    localparam logic [1:0] B_OUT   = 2'd3;

    logic [1:0]        state_reg, state_next;
    usc_item_t         item_reg;
    logic [DAYS_W-1:0] rest_reg, rest_next;
    logic [7:0]        year_reg, year_next;
    logic [1:0]        mod4_reg, mod4_next;
    logic [6:0]        mod100_reg, mod100_next;
    logic [8:0]        mod400_reg, mod400_next;
    logic [3:0]        month_reg, month_next;

    logic              leap;
    logic [YLEN_W-1:0] ylen;
    logic [MLEN_W-1:0] mlen;
    logic              take;

    assign leap = ((mod4_reg == '0) && (mod100_reg != '0)) || (mod400_reg == '0);
    assign ylen = leap ? DAYS_LEAP : DAYS_COMMON;
    assign mlen = month_len(leap, month_reg);
    assign take = pop_valid && pop_ready;

    // Year and month walk
    always_comb
    begin
        state_next  = state_reg;
        rest_next   = rest_reg;
        year_next   = year_reg;
        mod4_next   = mod4_reg;
        mod100_next = mod100_reg;
        mod400_next = mod400_reg;
        month_next  = month_reg;
        unique case (state_reg)
            B_IDLE:
            begin
                if (take)
                begin
                    rest_next   = pop_item.days;
                    year_next   = YEAR_OFS_EPOCH;
                    mod4_next   = EPOCH_MOD4;
                    mod100_next = EPOCH_MOD100;
                    mod400_next = EPOCH_MOD400;
                    state_next  = B_YEAR;
                end
            end
            B_YEAR:
            begin
                if (rest_reg < DAYS_W'(ylen))
                begin
                    month_next = '0;
                    state_next = B_MONTH;
                end
                else
                begin
                    rest_next   = rest_reg - DAYS_W'(ylen);
                    year_next   = year_reg + 8'd1;
                    mod4_next   = mod4_reg + 2'd1;
                    mod100_next = (mod100_reg == LAST_MOD100) ? '0 : mod100_reg + 7'd1;
                    mod400_next = (mod400_reg == LAST_MOD400) ? '0 : mod400_reg + 9'd1;
                end
            end
            B_MONTH:
            begin
                if ((month_reg < LAST_MONTH) && (rest_reg >= DAYS_W'(mlen)))
                begin
                    rest_next  = rest_reg - DAYS_W'(mlen);
                    month_next = month_reg + 4'd1;
                end
                else
                begin
                    state_next = B_OUT;
                end
            end
            B_OUT:
            begin
                if (out_ready)
                begin
                    state_next = B_IDLE;
                end
            end
            default:
            begin
                state_next = B_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= B_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Walk registers and the held word
    always_ff @(posedge clk)
    begin
        rest_reg   <= rest_next;
        year_reg   <= year_next;
        mod4_reg   <= mod4_next;
        mod100_reg <= mod100_next;
        mod400_reg <= mod400_next;
        month_reg  <= month_next;
        if (take)
        begin
            item_reg <= pop_item;
        end
    end

    assign pop_ready = (state_reg == B_IDLE);
    assign out_valid = (state_reg == B_OUT);

    assign echo_seconds     = item_reg.ts;
    assign second_of_minute = item_reg.sec;
    assign minute_of_hour   = item_reg.min;
    assign hour_of_day      = item_reg.hour;
    assign day_of_week      = item_reg.wday;
    assign year_offset      = year_reg;
    assign month_number     = month_reg + 4'd1;
    assign day_of_month     = rest_reg[4:0] + 5'd1;

endmodule

// ===== sv/unix_seconds_to_calendar.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// unix_seconds_to_calendar
// Converts a 32-bit count of seconds since 1970-01-01 into calendar fields.
// ----------------------------------------------------------------------------
// Each timestamp word gives one result word: time of day, weekday (Monday is
// 1), year as an offset from 2000 modulo 256, month and day of month, and the
// timestamp echoed back. The front takes a new word only once it has pushed
// its last result: reciprocal multiplications by constants give the day count,
// second of day, minute of day, weekday and hour, one product a cycle. The back
// then walks one year a cycle from 1970 and one month a cycle, and is ready for
// its next word in the cycle after its result leaves. A two-word queue sits
// between them, so the front keeps converting while a finished result waits at
// the output; the sustained rate is the slower of the two parts for the dates
// presented.
// ----------------------------------------------------------------------------
module unix_seconds_to_calendar
    import usc_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [TS_W-1:0]   timestamp,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [TS_W-1:0]   echo_seconds,
    output logic [5:0]        second_of_minute,
    output logic [5:0]        minute_of_hour,
    output logic [4:0]        hour_of_day,
    output logic [2:0]        day_of_week,
    output logic [7:0]        year_offset,
    output logic [3:0]        month_number,
    output logic [4:0]        day_of_month
);

    logic      push_valid;
    logic      push_ready;
    usc_item_t push_item;
    logic      pop_valid;
    logic      pop_ready;
    usc_item_t pop_item;

    usc_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .timestamp  (timestamp),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_item  (push_item)
    );

    usc_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_item  (push_item),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_item   (pop_item)
    );

    usc_back u_back (
        .clk              (clk),
        .rst_n            (rst_n),
        .pop_valid        (pop_valid),
        .pop_ready        (pop_ready),
        .pop_item         (pop_item),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .echo_seconds     (echo_seconds),
        .second_of_minute (second_of_minute),
        .minute_of_hour   (minute_of_hour),
        .hour_of_day      (hour_of_day),
        .day_of_week      (day_of_week),
        .year_offset      (year_offset),
        .month_number     (month_number),
        .day_of_month     (day_of_month)
    );

endmodule
